>>> hw/rtl/mkpd_pkg.sv
// Shared constants, types and helpers for the matrix keypad scanner.
// Depends on nothing; every other file imports it.
package mkpd_pkg;

  // matrix geometry and dwell counter width
  localparam int KEY_ROWS    = 4;
  localparam int KEY_COLUMNS = 4;
  localparam int DWELL_WIDTH = 16;

  // fixed field widths
  localparam int LEVELS_W = 4;
  localparam int DRIVE_W  = 4;
  localparam int CODE_W   = 5;
  localparam int CFG_W    = 16;

  // index widths derived from the geometry
  localparam int ROW_IDX_W = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
  localparam int COL_IDX_W = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(KEY_ROWS - 1);
  localparam logic [COL_IDX_W-1:0] LAST_COL = COL_IDX_W'(KEY_COLUMNS - 1);

  // largest count the dwell counter holds
  localparam logic [32:0] DWELL_MAX = 33'((64'd1 << DWELL_WIDTH) - 64'd1);

  typedef enum logic [1:0] {
    PH_MAIN_SAMPLE = 2'd0,
    PH_MAIN_DWELL  = 2'd1,
    PH_SUB_SAMPLE  = 2'd2,
    PH_SUB_DWELL   = 2'd3
  } phase_t;

  typedef logic [DWELL_WIDTH-1:0] dwell_t;

  // one result of the scan core
  typedef struct packed {
    logic [DRIVE_W-1:0] column_drive;
    logic               scan_done;
    logic [CODE_W-1:0]  key_code;
    logic               multi_key;
  } result_t;

  // register value clamped to the counter range
  function automatic dwell_t dwell_load(input logic [CFG_W-1:0] ticks);
    logic [32:0] wide;
    wide = 33'(ticks);
    if (wide > DWELL_MAX) begin
      return dwell_t'(DWELL_MAX);
    end
    return dwell_t'(wide);
  endfunction

endpackage

>>> hw/rtl/mkpd_if.sv
// Handshake channels of the keypad scanner: tick input, result output, config write.
// Depends on mkpd_pkg for field widths.
interface mkpd_tick_if;
  import mkpd_pkg::*;
  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] row_levels;
  modport source (output valid, output row_levels, input ready);
  modport sink (input valid, input row_levels, output ready);
endinterface

interface mkpd_result_if;
  import mkpd_pkg::*;
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] column_drive;
  logic               scan_done;
  logic [CODE_W-1:0]  key_code;
  logic               multi_key;
  modport source (output valid, output column_drive, output scan_done,
                  output key_code, output multi_key, input ready);
  modport sink (input valid, input column_drive, input scan_done,
                input key_code, input multi_key, output ready);
endinterface

interface mkpd_cfg_if;
  import mkpd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] dwell_ticks;
  modport source (output valid, output dwell_ticks, input ready);
  modport sink (input valid, input dwell_ticks, output ready);
endinterface

>>> hw/rtl/mkpd_scan_core.sv
// Scan state machine: main pass, held-key sub-scan and dwell counting.
// Depends on mkpd_pkg; takes one state step per registered tick.
module mkpd_scan_core
  import mkpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [LEVELS_W-1:0] row_levels,
  input  logic [CFG_W-1:0]    dwell_ticks,
  output result_t             result
);

  phase_t                phase, phase_next;
  logic [COL_IDX_W-1:0]  scan_column, scan_column_next;
  logic [ROW_IDX_W-1:0]  scan_row, scan_row_next;
  logic [COL_IDX_W-1:0]  probe_column, probe_column_next;
  logic [ROW_IDX_W-1:0]  probe_row, probe_row_next;
  dwell_t                dwell_count, dwell_count_next;
  logic [CODE_W-1:0]     found_key, found_key_next;
  logic                  multi_seen, multi_seen_next;

  logic [COL_IDX_W-1:0]  drive_col;
  logic [7:0]            drive_onehot;
  logic [7:0]            levels_ext;
  logic                  main_pressed;
  logic                  probe_pressed;
  dwell_t                load;
  dwell_t                count_dec;
  logic                  adv_main;
  logic                  adv_probe;

  // column drive and row sensing
  always_comb begin
    drive_col    = (phase == PH_SUB_SAMPLE || phase == PH_SUB_DWELL) ? probe_column
                                                                     : scan_column;
    drive_onehot = 8'd1 << drive_col;
    levels_ext   = {{(8 - LEVELS_W){1'b1}}, row_levels};
    main_pressed  = !levels_ext[3'(scan_row)];
    probe_pressed = !levels_ext[3'(probe_row)];
    load          = dwell_load(dwell_ticks);
    count_dec     = (dwell_count != '0) ? dwell_count - dwell_t'(1) : dwell_count;
  end

  // next state and result
  always_comb begin
    phase_next        = phase;
    scan_column_next  = scan_column;
    scan_row_next     = scan_row;
    probe_column_next = probe_column;
    probe_row_next    = probe_row;
    dwell_count_next  = dwell_count;
    found_key_next    = found_key;
    multi_seen_next   = multi_seen;
    adv_main          = 1'b0;
    adv_probe         = 1'b0;

    result.column_drive = ~drive_onehot[DRIVE_W-1:0];
    result.scan_done    = 1'b0;
    result.key_code     = '0;
    result.multi_key    = 1'b0;

    unique case (phase)
      PH_MAIN_SAMPLE: begin
        if (main_pressed) begin
          found_key_next    = CODE_W'(scan_row) + CODE_W'(KEY_ROWS) * CODE_W'(scan_column)
                              + CODE_W'(1);
          probe_column_next = '0;
          probe_row_next    = '0;
          phase_next        = PH_SUB_SAMPLE;
        end else if (load == '0) begin
          adv_main = 1'b1;
        end else begin
          dwell_count_next = load;
          phase_next       = PH_MAIN_DWELL;
        end
      end
      PH_MAIN_DWELL: begin
        dwell_count_next = count_dec;
        adv_main         = (count_dec == '0);
      end
      PH_SUB_SAMPLE: begin
        if (probe_pressed && probe_column != scan_column && probe_row != scan_row) begin
          multi_seen_next = 1'b1;
        end else if (load == '0) begin
          adv_probe = 1'b1;
        end else begin
          dwell_count_next = load;
          phase_next       = PH_SUB_DWELL;
        end
      end
      PH_SUB_DWELL: begin
        dwell_count_next = count_dec;
        adv_probe        = (count_dec == '0);
      end
      default: begin
        phase_next = PH_MAIN_SAMPLE;
      end
    endcase

    // step to the next main position, report at the end of a pass
    if (adv_main) begin
      phase_next = PH_MAIN_SAMPLE;
      if (scan_row != LAST_ROW) begin
        scan_row_next = scan_row + ROW_IDX_W'(1);
      end else begin
        scan_row_next = '0;
        if (scan_column != LAST_COL) begin
          scan_column_next = scan_column + COL_IDX_W'(1);
        end else begin
          scan_column_next = '0;
          result.scan_done = 1'b1;
          result.key_code  = found_key;
          result.multi_key = multi_seen;
          found_key_next   = '0;
          multi_seen_next  = 1'b0;
        end
      end
    end

    // step to the next probe position, back to main after the last one
    if (adv_probe) begin
      phase_next = PH_SUB_SAMPLE;
      if (probe_row != LAST_ROW) begin
        probe_row_next = probe_row + ROW_IDX_W'(1);
      end else begin
        probe_row_next = '0;
        if (probe_column != LAST_COL) begin
          probe_column_next = probe_column + COL_IDX_W'(1);
        end else begin
          probe_column_next = '0;
          phase_next        = PH_MAIN_SAMPLE;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAIN_SAMPLE;
      scan_column  <= '0;
      scan_row     <= '0;
      probe_column <= '0;
      probe_row    <= '0;
      dwell_count  <= '0;
      found_key    <= '0;
      multi_seen   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      scan_column  <= scan_column_next;
      scan_row     <= scan_row_next;
      probe_column <= probe_column_next;
      probe_row    <= probe_row_next;
      dwell_count  <= dwell_count_next;
      found_key    <= found_key_next;
      multi_seen   <= multi_seen_next;
    end
  end

endmodule

>>> hw/rtl/matrix_keypad_scanner.sv
// Top level of the 4x4 matrix keypad scanner: tick register, scan core, result register.
// Depends on mkpd_pkg, the channel interfaces in mkpd_if and mkpd_scan_core.
//
//   channel  dir  payload                                    request
//   tick     in   row_levels[3:0]                            one scan tick
//   result   out  column_drive, scan_done, key_code, multi   one per tick
//   cfg      in   dwell_ticks[15:0]                          register write
//
// Every tick request gives exactly one result request, through the tick register and then the result register.
// One tick can be taken in every cycle while the result side does not stall; the scan state register is the only loop.
// rst is synchronous: pipeline empties, dwell_ticks returns to 10, scan restarts.
// A stalled result holds both stages; tick ready drops only while the result
// register is full and not being taken.
module matrix_keypad_scanner
  import mkpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  mkpd_tick_if.sink          tick,
  mkpd_result_if.source      result,
  mkpd_cfg_if.sink           cfg
);

  logic                in_valid;
  logic [LEVELS_W-1:0] in_levels;
  logic                out_valid;
  result_t             out_data;
  result_t             core_result;
  logic [CFG_W-1:0]    dwell_ticks;
  logic                advance;

  // pipeline moves when the result register is free or being drained
  assign advance    = !out_valid || result.ready;
  assign tick.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= CFG_W'(10);
    end else if (cfg.valid) begin
      dwell_ticks <= cfg.dwell_ticks;
    end
  end

  // tick input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_levels <= tick.row_levels;
    end
  end

  mkpd_scan_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_valid && advance),
    .row_levels  (in_levels),
    .dwell_ticks (dwell_ticks),
    .result      (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_data <= core_result;
    end
  end

  assign result.valid        = out_valid;
  assign result.column_drive = out_data.column_drive;
  assign result.scan_done    = out_data.scan_done;
  assign result.key_code     = out_data.key_code;
  assign result.multi_key    = out_data.multi_key;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the 4x4 keypad scanner: directed table, long dwell, keypad traffic.
// Depends on mkpd_pkg, the channel interfaces in mkpd_if and matrix_keypad_scanner.
module tb_top;
  import mkpd_pkg::*;

  // column patterns and row levels used by the directed table
  localparam logic [DRIVE_W-1:0]  DRIVE_COL0 = 4'b1110;
  localparam logic [DRIVE_W-1:0]  DRIVE_COL3 = 4'b0111;
  localparam logic [CFG_W-1:0]    ROWS_OPEN  = 16'h000F;
  localparam logic [CFG_W-1:0]    ROWS_ALL   = 16'h0000;
  localparam logic [CFG_W-1:0]    ROW1_DOWN  = 16'h000D;
  localparam logic [CFG_W-1:0]    DWELL_LONG = 16'd200;
  localparam int                  PLAN_ROWS  = 10;
  localparam int                  LONG_TICKS = 201;
  localparam int                  MAX_PRINTS = 20;

  typedef enum logic {STEP_TICK, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic [CFG_W-1:0] value;
    logic [7:0]       count;
    logic             fixed;
    result_t          want;
  } plan_row_t;

  // directed walk: mid-wait register change, zero dwell, a held key with a
  // second key in another row and column, then the pass that reports both
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{STEP_CFG,  16'd1,      8'd1,  1'b0, '0},
    '{STEP_TICK, ROWS_OPEN,  8'd1,  1'b1, '{DRIVE_COL0, 1'b0, 5'd0, 1'b0}},
    '{STEP_CFG,  16'd0,      8'd1,  1'b0, '0},
    '{STEP_TICK, ROWS_OPEN,  8'd1,  1'b1, '{DRIVE_COL0, 1'b0, 5'd0, 1'b0}},
    '{STEP_TICK, ROW1_DOWN,  8'd1,  1'b1, '{DRIVE_COL0, 1'b0, 5'd0, 1'b0}},
    '{STEP_TICK, ROWS_OPEN,  8'd4,  1'b0, '0},
    '{STEP_TICK, ROWS_ALL,   8'd2,  1'b0, '0},
    '{STEP_TICK, ROWS_OPEN,  8'd26, 1'b0, '0},
    '{STEP_TICK, ROWS_OPEN,  8'd1,  1'b1, '{DRIVE_COL3, 1'b1, 5'd2, 1'b1}},
    '{STEP_CFG,  DWELL_LONG, 8'd1,  1'b0, '0}
  };

  // dwell settings of the random phases
  logic [CFG_W-1:0] dwell_plan [11] = '{16'd0, 16'd2, 16'd1, 16'd0, 16'd7, 16'd3, 16'd0,
                                        16'd1, 16'd10, 16'd4, 16'd0};

  logic clk;
  logic rst;

  mkpd_tick_if   tick_ch ();
  mkpd_result_if result_ch ();
  mkpd_cfg_if    cfg_ch ();

  matrix_keypad_scanner u_top (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // scanner state as predicted
  phase_t                 scan_phase;
  logic [COL_IDX_W-1:0]   scan_col;
  logic [ROW_IDX_W-1:0]   scan_row;
  logic [COL_IDX_W-1:0]   probe_col;
  logic [ROW_IDX_W-1:0]   probe_row;
  dwell_t                 dwell_left;
  logic [CODE_W-1:0]      found_code;
  logic                   multi_flag;
  logic [CFG_W-1:0]       dwell_setting;

  result_t predicted_scans [$];
  int      mismatch_count;
  int      stall_left;
  bit      calm;

  // keypad the scanner looks at
  logic [KEY_ROWS*KEY_COLUMNS-1:0] held_keys;
  int                              hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[matrix_keypad_scanner] ERROR");
    $finish;
  end

  function automatic logic [COL_IDX_W-1:0] driven_column();
    return (scan_phase == PH_SUB_SAMPLE || scan_phase == PH_SUB_DWELL) ? probe_col : scan_col;
  endfunction

  // next main position; the last one closes the pass and reports
  function automatic void advance_scan(inout result_t r);
    scan_phase = PH_MAIN_SAMPLE;
    if (scan_row != LAST_ROW) begin
      scan_row++;
      return;
    end
    scan_row = '0;
    if (scan_col != LAST_COL) begin
      scan_col++;
      return;
    end
    scan_col = '0;
    r.scan_done = 1'b1;
    r.key_code = found_code;
    r.multi_key = multi_flag;
    found_code = '0;
    multi_flag = 1'b0;
  endfunction

  // next sub-scan position; after the last one resample the held key
  function automatic void advance_probe();
    scan_phase = PH_SUB_SAMPLE;
    if (probe_row != LAST_ROW) begin
      probe_row++;
      return;
    end
    probe_row = '0;
    if (probe_col != LAST_COL) begin
      probe_col++;
      return;
    end
    probe_col = '0;
    scan_phase = PH_MAIN_SAMPLE;
  endfunction

  // one tick of the scanner: returns the outputs, moves the state
  function automatic result_t scan_tick(input logic [LEVELS_W-1:0] levels);
    result_t         r;
    dwell_t          reload;
    longint unsigned top;
    top = (64'd1 << DWELL_WIDTH) - 64'd1;
    if (64'(dwell_setting) > top) begin
      reload = dwell_t'(top);
    end else begin
      reload = dwell_t'(dwell_setting);
    end
    r = '0;
    r.column_drive = ~(DRIVE_W'(1) << driven_column());
    case (scan_phase)
      PH_MAIN_SAMPLE: begin
        if (!levels[scan_row]) begin
          found_code = CODE_W'(scan_row) + CODE_W'(KEY_ROWS) * CODE_W'(scan_col) + CODE_W'(1);
          probe_col = '0;
          probe_row = '0;
          scan_phase = PH_SUB_SAMPLE;
        end else if (reload == '0) begin
          advance_scan(r);
        end else begin
          dwell_left = reload;
          scan_phase = PH_MAIN_DWELL;
        end
      end
      PH_MAIN_DWELL: begin
        if (dwell_left != '0) dwell_left--;
        if (dwell_left == '0) advance_scan(r);
      end
      PH_SUB_SAMPLE: begin
        // a second key off the held key's row and column stalls here
        if (!levels[probe_row] && probe_col != scan_col && probe_row != scan_row) begin
          multi_flag = 1'b1;
        end else if (reload == '0) begin
          advance_probe();
        end else begin
          dwell_left = reload;
          scan_phase = PH_SUB_DWELL;
        end
      end
      default: begin
        if (dwell_left != '0) dwell_left--;
        if (dwell_left == '0) advance_probe();
      end
    endcase
    return r;
  endfunction

  // row levels seen through the driven column, with some line noise
  function automatic logic [LEVELS_W-1:0] keypad_levels();
    logic [LEVELS_W-1:0] lv;
    int                  col;
    if ($urandom_range(0, 99) < 15) return LEVELS_W'($urandom_range(0, 15));
    lv = '1;
    col = int'(driven_column());
    for (int r = 0; r < KEY_ROWS; r++) begin
      lv[r] = ~held_keys[r + KEY_ROWS * col];
    end
    return lv;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    end
  endtask

  // one tick request; valid stays high afterwards
  task automatic send_tick(input logic [LEVELS_W-1:0] lv, input bit fixed = 1'b0,
                           input result_t want = '0);
    result_t predicted;
    tick_ch.valid <= 1'b1;
    tick_ch.row_levels <= lv;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    predicted = scan_tick(lv);
    predicted_scans.push_back(fixed ? want : predicted);
  endtask

  task automatic idle_gap();
    int n;
    n = calm ? 0 : gap_len();
    if (n > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_scans();
    tick_ch.valid <= 1'b0;
    while (predicted_scans.size() != 0) @(posedge clk);
  endtask

  // register write only once the scanner has nothing in flight
  task automatic write_dwell(input logic [CFG_W-1:0] value);
    drain_scans();
    cfg_ch.valid <= 1'b1;
    cfg_ch.dwell_ticks <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    dwell_setting = value;
  endtask

  // result side: random stalls, compare against oldest prediction
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.column_drive, result_ch.scan_done, result_ch.key_code,
              result_ch.multi_key};
      if (predicted_scans.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got), 0);
      end else begin
        want = predicted_scans.pop_front();
        if (got.column_drive != want.column_drive)
          report_mismatch("column_drive", int'(got.column_drive), int'(want.column_drive));
        if (got.scan_done != want.scan_done)
          report_mismatch("scan_done", int'(got.scan_done), int'(want.scan_done));
        if (got.key_code != want.key_code)
          report_mismatch("key_code", int'(got.key_code), int'(want.key_code));
        if (got.multi_key != want.multi_key)
          report_mismatch("multi_key", int'(got.multi_key), int'(want.multi_key));
      end
    end
    if (calm) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left = gap_len();
    end
  end

  // stimulus
  initial begin
    int          n_items;
    int          a;
    int          b;
    int          pick;
    result_t     want;
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.row_levels = '1;
    cfg_ch.valid = 1'b0;
    cfg_ch.dwell_ticks = '0;
    result_ch.ready = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    mismatch_count = 0;
    held_keys = '0;
    hold_left = 0;
    scan_phase = PH_MAIN_SAMPLE;
    scan_col = '0;
    scan_row = '0;
    probe_col = '0;
    probe_row = '0;
    dwell_left = '0;
    found_code = '0;
    multi_flag = 1'b0;
    dwell_setting = 16'd10;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (directed_plan[i].kind == STEP_CFG) begin
        write_dwell(directed_plan[i].value);
      end else begin
        want = directed_plan[i].want;
        repeat (directed_plan[i].count) begin
          send_tick(directed_plan[i].value[LEVELS_W-1:0], directed_plan[i].fixed, want);
          idle_gap();
        end
      end
    end

    // long dwell run to the end, register changed halfway through the wait
    calm = 1'b1;
    send_tick(ROWS_OPEN[LEVELS_W-1:0]);
    for (int k = 1; k < LONG_TICKS; k++) begin
      if (k == LONG_TICKS / 2) write_dwell(16'd3);
      send_tick(LEVELS_W'($urandom_range(0, 15)));
    end
    calm = 1'b0;

    // random phases driven from a keypad with changing held keys
    for (int p = 0; p < 11; p++) begin
      write_dwell(dwell_plan[p]);
      calm = (p % 4 == 2);
      n_items = $urandom_range(60, 100);
      repeat (n_items) begin
        if (hold_left == 0) begin
          pick = $urandom_range(0, 99);
          a = $urandom_range(0, KEY_ROWS * KEY_COLUMNS - 1);
          b = $urandom_range(0, KEY_ROWS * KEY_COLUMNS - 1);
          if (pick < 30) held_keys = '0;
          else if (pick < 70) held_keys = 16'd1 << a;
          else if (pick < 90) held_keys = (16'd1 << a) | (16'd1 << b);
          else held_keys = 16'($urandom() & $urandom());
          hold_left = $urandom_range(4, 40 * (int'(dwell_setting) + 1));
        end
        hold_left--;
        send_tick(keypad_levels());
        idle_gap();
      end
    end

    drain_scans();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[matrix_keypad_scanner] OK");
    end else begin
      $display("[matrix_keypad_scanner] ERROR");
    end
    $finish;
  end

endmodule
